@@ rtl/fisr_pkg.sv @@
// Package for the fast reciprocal square root block.
// Holds constants and single-precision arithmetic helpers; no dependencies.
`default_nettype none
package fisr_pkg;

  localparam int unsigned NewtonStepsDefault = 1;
  localparam logic [31:0] RsqMagic = 32'h5f3759df;
  localparam logic [31:0] CanonNan = 32'h7FC00000;
  localparam logic [31:0] OneAndHalf = 32'h3FC00000;
  localparam logic [31:0] OneHalf = 32'h3F000000;

  // Round a normalized significand with exponent to a single-precision pattern.
  // sig holds a leading one at bit 47 (or less for tiny values), exp is the
  // unbiased-plus-127 exponent belonging to bit 47; sticky carries lost bits.
  function automatic logic [31:0] fp_pack(input logic sgn, input logic signed [11:0] exp_in,
                                          input logic [47:0] sig_in, input logic sticky_in);
    logic [47:0] sig;
    logic signed [11:0] e;
    logic [5:0] sh;
    logic st;
    logic [24:0] m;
    logic g;
    logic rb;
    logic [31:0] res;
    sig = sig_in;
    e = exp_in;
    st = sticky_in;
    res = '0;
    if (sig == '0) begin
      res = {sgn, 31'd0};
    end else begin
      // Subnormal result: shift right so the exponent is one.
      if (e < 12'sd1) begin
        if (e < -12'sd48) begin
          sh = 6'd49;
        end else begin
          sh = 6'(12'sd1 - e);
        end
        for (int i = 0; i < 49; i++) begin
          if (i < int'(sh)) begin
            st = st | sig[0];
            sig = sig >> 1;
          end
        end
        e = 12'sd0;
      end
      m = {1'b0, sig[47:24]};
      g = sig[23];
      rb = st | (|sig[22:0]);
      if (g && (rb || m[0])) begin
        m = m + 25'd1;
      end
      if (m[24]) begin
        m = m >> 1;
        e = e + 12'sd1;
      end else if (e == 12'sd0 && m[23]) begin
        e = 12'sd1;
      end
      if (e >= 12'sd255) begin
        res = {sgn, 8'hFF, 23'd0};
      end else begin
        res = {sgn, e[7:0], m[22:0]};
      end
    end
    return res;
  endfunction

  // Normalize a significand so its leading one sits at bit 47.
  function automatic logic [53:0] fp_norm(input logic [47:0] sig_in);
    logic [47:0] sig;
    logic [5:0] lz;
    logic found;
    sig = sig_in;
    lz = '0;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && sig[i]) begin
        found = 1'b1;
        lz = 6'(47 - i);
      end
    end
    return {lz, sig << lz};
  endfunction

  // Single-precision multiply, round to nearest even.
  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    logic sgn;
    logic a_nan;
    logic b_nan;
    logic a_inf;
    logic b_inf;
    logic a_zero;
    logic b_zero;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [47:0] p;
    logic [53:0] nr;
    logic signed [11:0] e;
    logic [31:0] res;
    sgn = a[31] ^ b[31];
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == '0);
    b_inf = (b[30:23] == 8'hFF) && (b[22:0] == '0);
    a_zero = a[30:0] == '0;
    b_zero = b[30:0] == '0;
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
    p = ma * mb;
    nr = fp_norm(p);
    // Product bit 46 has weight 2^(ea+eb-254); bit 47 is one higher.
    e = 12'(signed'({4'd0, (a[30:23] == 8'd0) ? 8'd1 : a[30:23]}))
      + 12'(signed'({4'd0, (b[30:23] == 8'd0) ? 8'd1 : b[30:23]}))
      - 12'sd126 - 12'(signed'({6'd0, nr[53:48]}));
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      res = CanonNan;
    end else if (a_inf || b_inf) begin
      res = {sgn, 8'hFF, 23'd0};
    end else begin
      res = fp_pack(sgn, e, nr[47:0], 1'b0);
    end
    return res;
  endfunction

  // Single-precision 1.5 - b, round to nearest even.
  function automatic logic [31:0] fp_sub_from_c(input logic [31:0] b);
    logic [31:0] a;
    logic bs;
    logic [7:0] ea;
    logic [7:0] eb;
    logic [8:0] d;
    logic [49:0] xa;
    logic [49:0] xb;
    logic sticky;
    logic [7:0] eb_eff;
    logic big_a;
    logic [49:0] hi;
    logic [49:0] lo;
    logic [7:0] ehi;
    logic [7:0] elo;
    logic shi;
    logic slo;
    logic [50:0] s;
    logic rs;
    logic [53:0] nr;
    logic [47:0] sig;
    logic signed [11:0] e;
    logic [31:0] res;
    a = OneAndHalf;
    bs = ~b[31];
    ea = a[30:23];
    eb = b[30:23];
    eb_eff = (eb == 8'd0) ? 8'd1 : eb;
    big_a = (ea > eb_eff) || ((ea == eb_eff) && (a[22:0] >= b[22:0]));
    hi = {2'b00, 1'b1, a[22:0], 24'd0};
    lo = {2'b00, (eb != 8'd0), b[22:0], 24'd0};
    ehi = ea;
    elo = eb_eff;
    shi = a[31];
    slo = bs;
    if (!big_a) begin
      hi = lo;
      lo = {2'b00, 1'b1, a[22:0], 24'd0};
      ehi = eb_eff;
      elo = ea;
      shi = bs;
      slo = a[31];
    end
    d = {1'b0, ehi} - {1'b0, elo};
    sticky = 1'b0;
    if (d > 9'd49) begin
      sticky = lo != '0;
      lo = '0;
    end else begin
      for (int i = 0; i < 50; i++) begin
        if (i < int'(d)) begin
          sticky = sticky | lo[0];
          lo = lo >> 1;
        end
      end
    end
    if (shi == slo) begin
      s = {1'b0, hi} + {1'b0, lo};
    end else begin
      s = {1'b0, hi} - {1'b0, lo} - {50'd0, sticky};
    end
    rs = shi;
    if (b[30:23] == 8'hFF) begin
      res = (b[22:0] != '0) ? CanonNan : {bs, 8'hFF, 23'd0};
    end else if (s == '0) begin
      res = 32'd0;
    end else begin
      // s holds the significand with bit 47 worth 2^(ehi-127).
      if (s[48]) begin
        sticky = sticky | s[0];
        sig = s[48:1];
        e = 12'(signed'({4'd0, ehi})) + 12'sd1;
      end else begin
        nr = fp_norm(s[47:0]);
        sig = nr[47:0];
        e = 12'(signed'({4'd0, ehi})) - 12'(signed'({6'd0, nr[53:48]}));
      end
      res = fp_pack(rs, e, sig, sticky);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/fast_inverse_sqrt_top.sv @@
// Fast reciprocal square root: magic-constant guess and Newton steps.
// Throughput is one item per cycle.
// Each register stage holds one single-precision multiply or subtract.
// The receiver cannot stall; busy is always low.
// Reset clears the valid bits only; data registers are not reset.
// Depends on fisr_pkg.
`default_nettype none
module fast_inverse_sqrt_top
  import fisr_pkg::*;
#(
  parameter int unsigned NEWTON_STEPS = NewtonStepsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] value_bits_i,
  output logic             done_o,
  output logic [31:0]      rsqrt_bits_o
);

  localparam int unsigned Stages = 1 + 4 * NEWTON_STEPS;

  logic [Stages-1:0] vld_q;
  logic [31:0] hx_q [Stages];
  logic [31:0] y_q [Stages];
  logic [31:0] t_q [Stages];

  assign busy = 1'b0;

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Stages-2:0], start};
    end
  end

  // First stage: half of x and the bit-level guess.
  always_ff @(posedge clk_i) begin
    hx_q[0] <= fp_mul(value_bits_i, OneHalf);
    y_q[0]  <= RsqMagic - {value_bits_i[31], value_bits_i[31:1]};
    t_q[0]  <= '0;
  end

  // Newton steps, four stages each: hx*y, *y, 1.5-t, y*t.
  for (genvar s = 1; s < Stages; s++) begin : g_stage
    always_ff @(posedge clk_i) begin
      hx_q[s] <= hx_q[s-1];
      case ((s - 1) % 4)
        0: begin
          t_q[s] <= fp_mul(hx_q[s-1], y_q[s-1]);
          y_q[s] <= y_q[s-1];
        end
        1: begin
          t_q[s] <= fp_mul(t_q[s-1], y_q[s-1]);
          y_q[s] <= y_q[s-1];
        end
        2: begin
          t_q[s] <= fp_sub_from_c(t_q[s-1]);
          y_q[s] <= y_q[s-1];
        end
        default: begin
          t_q[s] <= t_q[s-1];
          y_q[s] <= fp_mul(y_q[s-1], t_q[s-1]);
        end
      endcase
    end
  end

  assign done_o = vld_q[Stages-1];
  assign rsqrt_bits_o = ((y_q[Stages-1][30:23] == 8'hFF) && (y_q[Stages-1][22:0] != '0))
                        ? CanonNan : y_q[Stages-1];

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the fast reciprocal square root block.
// Drives raw single-precision inputs and checks each result against a bit-exact
// integer model of the guess and Newton step; depends on fisr_pkg and the RTL.
`default_nettype none

module testbench;
  import fisr_pkg::*;

  // Round a magnitude mag * 2^scale to single precision, nearest even.
  function automatic logic [31:0] sp_round(input logic sgn, input int scale,
                                           input logic [63:0] mag);
    int lead;
    int bexp;
    int rsh;
    logic [63:0] m;
    logic g;
    logic st;
    lead = 0;
    g = 1'b0;
    st = 1'b0;
    if (mag == '0) return {sgn, 31'd0};
    for (int i = 0; i < 64; i++) if (mag[i]) lead = i;
    bexp = scale + lead - 23 + 150;
    if (bexp < 1) bexp = 1;
    rsh = bexp - 150 - scale;
    if (rsh <= 0) begin
      m = mag << (-rsh);
    end else if (rsh > 64) begin
      m = '0;
      st = 1'b1;
    end else begin
      g = mag[rsh-1];
      st = |(mag & ((64'd1 << (rsh - 1)) - 64'd1));
      m = mag >> rsh;
    end
    if (g && (st || m[0])) m = m + 64'd1;
    if (m[24]) begin
      m = m >> 1;
      bexp = bexp + 1;
    end
    if (bexp >= 255) return {sgn, 8'hFF, 23'd0};
    return {sgn, (m[23] ? 8'(bexp) : 8'd0), m[22:0]};
  endfunction

  // Single-precision product of two patterns.
  function automatic logic [31:0] sp_product(input logic [31:0] a, input logic [31:0] b);
    logic sgn;
    logic a_special;
    logic b_special;
    logic a_zero;
    logic b_zero;
    int ea;
    int eb;
    sgn = a[31] ^ b[31];
    a_special = a[30:23] == 8'hFF;
    b_special = b[30:23] == 8'hFF;
    a_zero = a[30:0] == '0;
    b_zero = b[30:0] == '0;
    if ((a_special && a[22:0] != '0) || (b_special && b[22:0] != '0)) return CanonNan;
    if ((a_special && b_zero) || (b_special && a_zero)) return CanonNan;
    if (a_special || b_special) return {sgn, 8'hFF, 23'd0};
    ea = (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
    eb = (b[30:23] == 8'd0) ? 1 : int'(b[30:23]);
    return sp_round(sgn, ea + eb - 300,
                    64'({a[30:23] != 8'd0, a[22:0]}) * 64'({b[30:23] != 8'd0, b[22:0]}));
  endfunction

  // Single-precision difference 1.5 - t, with the smaller operand's lost bits
  // jammed into the lowest bit.
  function automatic logic [31:0] sp_three_halves_minus(input logic [31:0] t);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] hi;
    logic [31:0] lo;
    logic [63:0] mhi;
    logic [63:0] mlo;
    logic [63:0] sum;
    int ehi;
    int elo;
    int d;
    logic jam;
    a = OneAndHalf;
    b = {~t[31], t[30:0]};
    if (t[30:23] == 8'hFF) return (t[22:0] != '0) ? CanonNan : {b[31], 8'hFF, 23'd0};
    if (a[30:0] >= b[30:0]) begin
      hi = a;
      lo = b;
    end else begin
      hi = b;
      lo = a;
    end
    ehi = (hi[30:23] == 8'd0) ? 1 : int'(hi[30:23]);
    elo = (lo[30:23] == 8'd0) ? 1 : int'(lo[30:23]);
    mhi = 64'({hi[30:23] != 8'd0, hi[22:0]}) << 30;
    mlo = 64'({lo[30:23] != 8'd0, lo[22:0]}) << 30;
    d = ehi - elo;
    if (d > 60) begin
      jam = mlo != '0;
      mlo = '0;
    end else begin
      jam = |(mlo & ((64'd1 << d) - 64'd1));
      mlo = mlo >> d;
    end
    mlo[0] = mlo[0] | jam;
    sum = (hi[31] == lo[31]) ? mhi + mlo : mhi - mlo;
    if (sum == '0) return 32'd0;
    return sp_round(hi[31], ehi - 150 - 30, sum);
  endfunction

  // Magic-constant guess refined by Newton steps.
  function automatic logic [31:0] predict_rsqrt(input logic [31:0] v);
    logic [31:0] half_x;
    logic [31:0] y;
    logic [31:0] t;
    half_x = sp_product(v, OneHalf);
    y = RsqMagic - {v[31], v[31:1]};
    for (int k = 0; k < NewtonStepsDefault; k++) begin
      t = sp_product(half_x, y);
      t = sp_product(t, y);
      t = sp_three_halves_minus(t);
      y = sp_product(y, t);
    end
    if (y[30:23] == 8'hFF && y[22:0] != '0) y = CanonNan;
    return y;
  endfunction

  // Holds the predicted results in issue order.
  class rsqrt_scoreboard;
    logic [31:0] pending_rsqrt[$];
    logic [31:0] pending_value[$];

    function void note_input(logic [31:0] v);
      pending_rsqrt.push_back(predict_rsqrt(v));
      pending_value.push_back(v);
    endfunction

    // Returns 0 with no expectation waiting, 1 on a match, 2 on a mismatch.
    function int check_result(logic [31:0] got, output logic [31:0] want,
                              output logic [31:0] v);
      want = '0;
      v = '0;
      if (pending_rsqrt.size() == 0) return 0;
      want = pending_rsqrt.pop_front();
      v = pending_value.pop_front();
      return (got === want) ? 1 : 2;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic [31:0] value_bits_i;
  logic done_o;
  logic [31:0] rsqrt_bits_o;

  rsqrt_scoreboard board;
  int errors;
  int items_sent;
  int results_seen;
  int idle_pct;

  fast_inverse_sqrt_top u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .value_bits_i(value_bits_i),
    .done_o(done_o),
    .rsqrt_bits_o(rsqrt_bits_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  // Record accepted items and check results at each rising edge.
  always @(posedge clk_i) begin
    logic [31:0] want;
    logic [31:0] v;
    int verdict;
    if (rst_ni) begin
      if (done_o) begin
        results_seen++;
        verdict = board.check_result(rsqrt_bits_o, want, v);
        if (verdict == 0) begin
          report($sformatf("result %h with no item outstanding", rsqrt_bits_o));
        end else if (verdict == 2) begin
          report($sformatf("input %h: rsqrt_bits %h, expected %h", v, rsqrt_bits_o, want));
        end
      end
      if (start && !busy) begin
        board.note_input(value_bits_i);
        items_sent++;
      end
    end
  end

  // Present one item and hold it until the block takes it.
  task automatic send_item(input logic [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    value_bits_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Random value: mostly positive normals, the rest any bit pattern.
  function automatic logic [31:0] random_value();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(99) < 60) begin
      v[31] = 1'b0;
      v[30:23] = 8'($urandom_range(254, 1));
    end
    return v;
  endfunction

  task automatic run_phase(input int pct, input int count);
    idle_pct = pct;
    for (int i = 0; i < count; i++) send_item(random_value());
  endtask

  initial begin
    logic [31:0] directed [21] = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
                                   32'h7FC00000, 32'h7F800001, 32'hFFFFFFFF, 32'h00000001,
                                   32'h00000002, 32'h007FFFFF, 32'h00800000, 32'h7F7FFFFF,
                                   32'h3F800000, 32'h40800000, 32'h3E800000, 32'hBF800000,
                                   32'h80000001, 32'h5F3759DF, 32'h55555555, 32'hAAAAAAAA,
                                   32'h7FFFFFFF};
    board = new();
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    idle_pct = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    value_bits_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corner values, then random traffic at three idle rates.
    idle_pct = 28;
    foreach (directed[i]) send_item(directed[i]);
    run_phase(28, 160);
    run_phase(81, 160);
    run_phase(0, 160);
    start <= 1'b0;

    // Drain the pipeline, then allow a few spare cycles.
    while (board.pending_rsqrt.size() != 0) @(posedge clk_i);
    repeat (4 * NewtonStepsDefault + 6) @(posedge clk_i);

    $display("Ran %0d items through the block and checked %0d results.",
             items_sent, results_seen);
    $display("Covered zeros, infinities, NaNs, subnormals and negative inputs.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
